FILE: hw/rtl/ghp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants for the generational handle pool.
// ---------------------------------------------------------------------------
package ghp_pkg;

    localparam int SLOTS_DEF        = 1024;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int CMD_W       = 3;
    localparam int IDX_FIELD_W = 10;
    localparam int GEN_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 11;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [GEN_W-1:0] GEN_MAX   = 8'hFF;
    localparam logic [GEN_W-1:0] GEN_WRAP  = 8'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_CONTAINS  = 3'd2,
        CMD_READ      = 3'd3,
        CMD_WRITE     = 3'd4,
        CMD_WRITE_CUR = 3'd5,
        CMD_READ_PREV = 3'd6,
        CMD_SNAPSHOT  = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_STALE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SNAP,
        S_RESP
    } state_t;

endpackage : ghp_pkg
`default_nettype wire

FILE: hw/rtl/ghp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ghp_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : ghp_ram
`default_nettype wire

FILE: hw/rtl/generational_handle_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// generational_handle_pool
// Slot map of payload words addressed by (index, generation) handles, with a
// LIFO free list, a high-water mark and a current/previous payload snapshot.
//
//   Channel  Dir  Handshake          Moves
//   s_       in   s_tvalid/s_tready  command request
//   m_       out  m_tvalid/m_tready  one result per request
//   APB      in   psel/penable       capacity_limit register
//
// Every request except snapshot reads the slot RAMs, then does the check,
// write-back and result. Snapshot copies each slot below the high-water
// mark, one per cycle, through the current-payload read port. A waiting
// result does not block the next request; a second result stalls in the
// execute or response state until the output register frees up. Reset
// needs no clearing pass: slots at or above the high-water mark read as
// never used.
// ---------------------------------------------------------------------------
module generational_handle_pool
    import ghp_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int S_TDATA_W   = ((CMD_W + IDX_FIELD_W + GEN_W + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W   =
        ((STATUS_W + 2 * IDX_FIELD_W + GEN_W + PAYLOAD_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command, handle_index, handle_generation, payload_in
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // status, out_index, out_generation, payload_out, live_total
    output logic      [M_TDATA_W-1:0]  m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int HW_W   = IDX_W + 1;
    localparam int CMP_W  = (HW_W > CFG_W) ? HW_W : CFG_W;
    localparam int META_W = IDX_W + 1 + GEN_W;
    localparam int PB     = PAYLOAD_BITS;

    localparam int IN_IDX_O  = CMD_W;
    localparam int IN_GEN_O  = IN_IDX_O + IDX_FIELD_W;
    localparam int IN_PAY_O  = IN_GEN_O + GEN_W;
    localparam int OUT_IDX_O = STATUS_W;
    localparam int OUT_GEN_O = OUT_IDX_O + IDX_FIELD_W;
    localparam int OUT_PAY_O = OUT_GEN_O + GEN_W;
    localparam int OUT_LIV_O = OUT_PAY_O + PB;

    // state
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic [GEN_W-1:0]       gen_reg;
    logic [PB-1:0]          pay_reg;
    logic [HW_W-1:0]        hw_reg, hw_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       live_reg, live_next;
    logic [CFG_W-1:0]       cap_reg;
    logic [HW_W-1:0]        snap_idx_reg, snap_idx_next;
    logic                   snap_wr_reg, snap_wr_next;
    logic [IDX_W-1:0]       snap_addr_reg, snap_addr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // RAM ports
    logic                   meta_we, meta_re;
    logic [IDX_W-1:0]       meta_waddr, meta_raddr;
    logic [META_W-1:0]      meta_wdata, meta_rdata;
    logic                   cur_we, cur_re;
    logic [IDX_W-1:0]       cur_waddr, cur_raddr;
    logic [PB-1:0]          cur_wdata, cur_rdata;
    logic                   prev_we, prev_re;
    logic [IDX_W-1:0]       prev_waddr, prev_raddr;
    logic [PB-1:0]          prev_wdata, prev_rdata;

    logic                   accept, out_free, cfg_wr;
    logic [IDX_FIELD_W-1:0] s_idx;
    logic [IDX_W-1:0]       h_addr;
    logic [GEN_W-1:0]       meta_gen, new_gen;
    logic                   meta_live;
    logic [IDX_W-1:0]       meta_link;
    logic [CMP_W-1:0]       cap_eff;
    logic                   handle_ok;
    status_t                status;
    logic [IDX_W-1:0]       out_slot;
    logic [GEN_W-1:0]       out_gen;
    logic [PB-1:0]          pout;
    logic                   load_out;

    ghp_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta_ram (
        .aclk(aclk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
    );

    ghp_ram #(.WIDTH(PB), .DEPTH(SLOTS)) u_cur_ram (
        .aclk(aclk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .re(cur_re), .raddr(cur_raddr), .rdata(cur_rdata)
    );

    ghp_ram #(.WIDTH(PB), .DEPTH(SLOTS)) u_prev_ram (
        .aclk(aclk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .re(prev_re), .raddr(prev_raddr), .rdata(prev_rdata)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? APB_DATA_W'(cap_reg) : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign s_idx     = s_tdata[IN_IDX_O +: IDX_FIELD_W];
    assign h_addr    = IDX_W'(idx_reg);
    assign meta_gen  = meta_rdata[GEN_W-1:0];
    assign meta_live = meta_rdata[GEN_W];
    assign meta_link = meta_rdata[META_W-1 -: IDX_W];
    assign new_gen   = (meta_gen == GEN_MAX) ? GEN_WRAP : meta_gen + GEN_WRAP;
    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(cap_reg);
    assign handle_ok = (idx_reg != '0) && (CMP_W'(idx_reg) < CMP_W'(hw_reg))
                       && meta_live && (meta_gen == gen_reg);

    always_comb begin
        state_next     = state_reg;
        hw_next        = hw_reg;
        head_next      = head_reg;
        live_next      = live_reg;
        snap_idx_next  = snap_idx_reg;
        snap_wr_next   = 1'b0;
        snap_addr_next = snap_addr_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        meta_re    = accept;
        meta_raddr = (cmd_t'(s_tdata[CMD_W-1:0]) == CMD_INSERT) ? head_reg : IDX_W'(s_idx);
        meta_we    = 1'b0;
        meta_waddr = h_addr;
        meta_wdata = {head_reg, 1'b0, meta_gen};
        cur_re     = accept;
        cur_raddr  = IDX_W'(s_idx);
        cur_we     = 1'b0;
        cur_waddr  = h_addr;
        cur_wdata  = pay_reg;
        prev_re    = accept;
        prev_raddr = IDX_W'(s_idx);
        prev_we    = 1'b0;
        prev_waddr = h_addr;
        prev_wdata = pay_reg;

        status   = STAT_OK;
        out_slot = '0;
        out_gen  = '0;
        pout     = '0;
        load_out = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd_reg == CMD_SNAPSHOT) begin
                    state_next    = S_SNAP;
                    snap_idx_next = '0;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg == CMD_INSERT) begin
                        if (head_reg != '0) begin
                            out_slot  = head_reg;
                            out_gen   = new_gen;
                            head_next = meta_link;
                        end else if (CMP_W'(hw_reg) < cap_eff) begin
                            out_slot = IDX_W'(hw_reg);
                            out_gen  = GEN_WRAP;
                            hw_next  = hw_reg + 1'b1;
                        end else begin
                            status = STAT_FULL;
                        end
                        if (status == STAT_OK) begin
                            meta_we    = 1'b1;
                            meta_waddr = out_slot;
                            meta_wdata = {meta_link, 1'b1, out_gen};
                            cur_we     = 1'b1;
                            cur_waddr  = out_slot;
                            prev_we    = 1'b1;
                            prev_waddr = out_slot;
                            live_next  = live_reg + 1'b1;
                        end
                    end else if (!handle_ok) begin
                        status = STAT_STALE;
                    end else begin
                        case (cmd_reg)
                            CMD_REMOVE: begin
                                meta_we   = 1'b1;
                                head_next = h_addr;
                                live_next = live_reg - 1'b1;
                            end
                            CMD_READ:      pout = cur_rdata;
                            CMD_READ_PREV: pout = prev_rdata;
                            CMD_WRITE: begin
                                cur_we  = 1'b1;
                                prev_we = 1'b1;
                            end
                            CMD_WRITE_CUR: cur_we = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            S_SNAP: begin
                prev_we    = snap_wr_reg;
                prev_waddr = snap_addr_reg;
                prev_wdata = cur_rdata;
                if (snap_idx_reg < hw_reg) begin
                    cur_re         = 1'b1;
                    cur_raddr      = snap_idx_reg[IDX_W-1:0];
                    snap_wr_next   = 1'b1;
                    snap_addr_next = snap_idx_reg[IDX_W-1:0];
                    snap_idx_next  = snap_idx_reg + 1'b1;
                end else if (!snap_wr_reg) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[STATUS_W-1:0]             = status;
            m_data_next[OUT_IDX_O +: IDX_FIELD_W] = IDX_FIELD_W'(out_slot);
            m_data_next[OUT_GEN_O +: GEN_W]       = out_gen;
            m_data_next[OUT_PAY_O +: PB]          = pout;
            m_data_next[OUT_LIV_O +: IDX_FIELD_W] = IDX_FIELD_W'(live_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            hw_reg        <= HW_W'(1);
            head_reg      <= '0;
            live_reg      <= '0;
            cap_reg       <= CAP_RESET;
            snap_idx_reg  <= '0;
            snap_wr_reg   <= 1'b0;
            snap_addr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hw_reg        <= hw_next;
            head_reg      <= head_next;
            live_reg      <= live_next;
            snap_idx_reg  <= snap_idx_next;
            snap_wr_reg   <= snap_wr_next;
            snap_addr_reg <= snap_addr_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr) begin
                cap_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            cmd_reg <= cmd_t'(s_tdata[CMD_W-1:0]);
            idx_reg <= s_idx;
            gen_reg <= s_tdata[IN_GEN_O +: GEN_W];
            pay_reg <= s_tdata[IN_PAY_O +: PB];
        end
    end

`ifndef SYNTH
    a_live_below_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        HW_W'(live_reg) < hw_reg)
        else $error("live count reached high-water mark");

    a_hw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hw_reg != '0) && (CMP_W'(hw_reg) <= CMP_W'(SLOTS)))
        else $error("high-water mark out of range");

    a_head_grown: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == '0) || (HW_W'(head_reg) < hw_reg))
        else $error("free list head above high-water mark");

    a_load_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_RESP))
        else $error("result loaded outside execute or response");

    a_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[OUT_IDX_O +: IDX_FIELD_W] != '0))
            |-> (m_data_reg[OUT_GEN_O +: GEN_W] != '0))
        else $error("handle issued with generation zero");
`endif

endmodule : generational_handle_pool
`default_nettype wire

FILE: tb/generational_handle_pool_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// generational_handle_pool_tb
// Self-checking bench for the generational handle pool. A tracker class
// models the slot map and predicts each result. Requests are directed, then
// random, across several capacity settings, including a run that keeps
// reusing one slot.
// ---------------------------------------------------------------------------
module generational_handle_pool_tb;
    import ghp_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int TIMEOUT_NS = 40_000_000;
    localparam int PAY_W      = PAYLOAD_BITS_DEF;
    localparam int S_TDATA_W  = ((CMD_W + IDX_FIELD_W + GEN_W + PAY_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((STATUS_W + 2 * IDX_FIELD_W + GEN_W + PAY_W + 7) / 8) * 8;
    localparam int IDX_LO     = STATUS_W;
    localparam int GEN_LO     = IDX_LO + IDX_FIELD_W;
    localparam int PAY_LO     = GEN_LO + GEN_W;
    localparam int LIVE_LO    = PAY_LO + PAY_W;
    localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = 3'd0;

    typedef struct packed {
        status_t                status;
        logic [IDX_FIELD_W-1:0] index;
        logic [GEN_W-1:0]       generation;
        logic [PAY_W-1:0]       payload;
        logic [IDX_FIELD_W-1:0] live_total;
    } pool_result_t;

    class handle_pool_tracker;
        bit               live      [SLOTS_DEF];
        logic [GEN_W-1:0] slot_gen  [SLOTS_DEF];
        int unsigned      free_link [SLOTS_DEF];
        logic [PAY_W-1:0] cur_word  [SLOTS_DEF];
        logic [PAY_W-1:0] prev_word [SLOTS_DEF];
        int unsigned      free_head;
        int unsigned      high_water;
        int unsigned      live_count;
        int unsigned      capacity;
        pool_result_t     awaited_results [$];
        status_t          last_status;
        int unsigned      last_slot;
        logic [GEN_W-1:0] last_gen;
        int               errors;
        int               results_seen;

        function new();
            for (int i = 0; i < SLOTS_DEF; i++) begin
                live[i]      = 1'b0;
                slot_gen[i]  = '0;
                free_link[i] = 0;
                cur_word[i]  = '0;
                prev_word[i] = '0;
            end
            free_head    = 0;
            high_water   = 1;
            live_count   = 0;
            capacity     = CAP_RESET;
            last_status  = STAT_OK;
            last_slot    = 0;
            last_gen     = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function bit handle_valid(int unsigned idx, logic [GEN_W-1:0] gen);
            if (idx == 0 || idx >= high_water || idx >= SLOTS_DEF)
                return 1'b0;
            return live[idx] && slot_gen[idx] == gen;
        endfunction

        function void note_request(cmd_t c, logic [IDX_FIELD_W-1:0] idx,
                                   logic [GEN_W-1:0] gen, logic [PAY_W-1:0] pay);
            pool_result_t r;
            int unsigned  cap;
            int unsigned  slot;
            r        = '0;
            r.status = STAT_OK;
            case (c)
                CMD_INSERT: begin
                    cap  = (capacity > SLOTS_DEF) ? SLOTS_DEF : capacity;
                    slot = 0;
                    if (free_head != 0) begin
                        slot      = free_head;
                        free_head = free_link[slot];
                    end else if (high_water < cap) begin
                        slot = high_water;
                        high_water++;
                    end
                    if (slot != 0) begin
                        slot_gen[slot]  = (slot_gen[slot] == GEN_MAX) ? GEN_WRAP
                                                                       : slot_gen[slot] + 8'd1;
                        cur_word[slot]  = pay;
                        prev_word[slot] = pay;
                        live[slot]      = 1'b1;
                        live_count++;
                        r.index      = IDX_FIELD_W'(slot);
                        r.generation = slot_gen[slot];
                        last_slot    = slot;
                        last_gen     = slot_gen[slot];
                    end else begin
                        r.status = STAT_FULL;
                    end
                end
                CMD_SNAPSHOT: begin
                    for (int i = 0; i < high_water && i < SLOTS_DEF; i++)
                        prev_word[i] = cur_word[i];
                end
                default: begin
                    if (!handle_valid(idx, gen)) begin
                        r.status = STAT_STALE;
                    end else begin
                        case (c)
                            CMD_REMOVE: begin
                                live[idx]      = 1'b0;
                                free_link[idx] = free_head;
                                free_head      = idx;
                                live_count--;
                            end
                            CMD_READ:      r.payload = cur_word[idx];
                            CMD_WRITE: begin
                                cur_word[idx]  = pay;
                                prev_word[idx] = pay;
                            end
                            CMD_WRITE_CUR: cur_word[idx] = pay;
                            CMD_READ_PREV: r.payload = prev_word[idx];
                            default: ;
                        endcase
                    end
                end
            endcase
            r.live_total = live_count[IDX_FIELD_W-1:0];
            last_status  = r.status;
            awaited_results.push_back(r);
        endfunction

        task flag_mismatch(string what);
            $display("error: %s", what);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [IDX_FIELD_W-1:0] idx,
                          logic [GEN_W-1:0] gen, logic [PAY_W-1:0] pay,
                          logic [IDX_FIELD_W-1:0] lt);
            pool_result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result %0d with no request pending", results_seen));
                return;
            end
            want = awaited_results.pop_front();
            if (st !== want.status)
                flag_mismatch($sformatf("result %0d status got %0d want %0d",
                                        results_seen, st, want.status));
            if (idx !== want.index)
                flag_mismatch($sformatf("result %0d out_index got %0d want %0d",
                                        results_seen, idx, want.index));
            if (gen !== want.generation)
                flag_mismatch($sformatf("result %0d out_generation got %0d want %0d",
                                        results_seen, gen, want.generation));
            if (pay !== want.payload)
                flag_mismatch($sformatf("result %0d payload_out got %h want %h",
                                        results_seen, pay, want.payload));
            if (lt !== want.live_total)
                flag_mismatch($sformatf("result %0d live_total got %0d want %0d",
                                        results_seen, lt, want.live_total));
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    handle_pool_tracker board;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    generational_handle_pool uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Called at a falling edge; returns at a falling edge.
    task automatic send_request(input cmd_t c, input logic [IDX_FIELD_W-1:0] idx,
                                input logic [GEN_W-1:0] gen, input logic [PAY_W-1:0] pay);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        if ($urandom_range(0, 31) == 0)
            send_steady = !send_steady;
        gap  = send_steady ? 0 : $urandom_range(0, 3);
        word = S_TDATA_W'({pay, gen, idx, c});
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(c, idx, gen, pay);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write capacity_limit, then read it back.
    task automatic set_capacity(input int unsigned value);
        logic [APB_DATA_W-1:0] word;
        word = {21'd0, value[CFG_W-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.capacity = value[CFG_W-1:0];
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== word)
            board.flag_mismatch($sformatf("capacity_limit read %0d want %0d", prdata, word));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_request();
        cmd_t               c;
        logic [IDX_FIELD_W-1:0] idx;
        logic [GEN_W-1:0]   gen;
        logic [PAY_W-1:0]   pay;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      c = CMD_INSERT;
        else if (pick < 50) c = CMD_REMOVE;
        else if (pick < 57) c = CMD_CONTAINS;
        else if (pick < 67) c = CMD_READ;
        else if (pick < 77) c = CMD_WRITE;
        else if (pick < 86) c = CMD_WRITE_CUR;
        else if (pick < 96) c = CMD_READ_PREV;
        else                c = CMD_SNAPSHOT;
        pay = {$urandom, $urandom};
        idx = IDX_FIELD_W'($urandom_range(0, SLOTS_DEF - 1));
        gen = GEN_W'($urandom_range(0, 255));
        if (board.live_count > 0 && $urandom_range(0, 99) < 75) begin
            for (int k = 0; k < 64; k++) begin
                idx = IDX_FIELD_W'($urandom_range(1, board.high_water - 1));
                if (board.live[idx])
                    break;
            end
            gen = board.slot_gen[idx];
            if ($urandom_range(0, 9) == 0)
                gen = gen + 8'd1;
        end else begin
            case ($urandom_range(0, 3))
                0: ;
                1: idx = '0;
                2: if (board.high_water < SLOTS_DEF) idx = IDX_FIELD_W'(board.high_water);
                default: begin
                    idx = IDX_FIELD_W'($urandom_range(0, board.high_water - 1));
                    gen = board.slot_gen[idx];
                end
            endcase
        end
        send_request(c, idx, gen, pay);
    endtask

    // result side
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                recv_steady = !recv_steady;
            gap = recv_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata[STATUS_W-1:0], m_tdata[IDX_LO +: IDX_FIELD_W],
                               m_tdata[GEN_LO +: GEN_W], m_tdata[PAY_LO +: PAY_W],
                               m_tdata[LIVE_LO +: IDX_FIELD_W]);
            @(negedge aclk);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [IDX_FIELD_W-1:0] h1;
        logic [IDX_FIELD_W-1:0] h2;
        logic [GEN_W-1:0]       g1;
        logic [GEN_W-1:0]       g2;
        int unsigned            caps [7];
        logic [IDX_FIELD_W-1:0] wi;
        logic [GEN_W-1:0]       wg;
        board    = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        send_request(CMD_READ, 10'd0, 8'd0, '1);
        send_request(CMD_CONTAINS, 10'd0, 8'd1, '0);
        send_request(CMD_INSERT, 10'd0, 8'd0, '1);
        h1 = IDX_FIELD_W'(board.last_slot);
        g1 = board.last_gen;
        send_request(CMD_INSERT, 10'h3FF, 8'hFF, '0);
        h2 = IDX_FIELD_W'(board.last_slot);
        g2 = board.last_gen;
        send_request(CMD_READ, h1, g1, '0);
        send_request(CMD_READ, h2, g2, '1);
        send_request(CMD_CONTAINS, h1, g1 + 8'd1, '0);
        send_request(CMD_CONTAINS, 10'h3FF, 8'hFF, '0);
        send_request(CMD_WRITE, h1, g1, 64'hA5A5_0F0F_3C3C_FFFF);
        send_request(CMD_WRITE_CUR, h1, g1, 64'h5A5A_F0F0_C3C3_0000);
        send_request(CMD_READ_PREV, h1, g1, '0);
        send_request(CMD_READ, h1, g1, '0);
        send_request(CMD_SNAPSHOT, 10'd0, 8'd0, '0);
        send_request(CMD_READ_PREV, h1, g1, '0);
        send_request(CMD_REMOVE, h1, g1, '0);
        send_request(CMD_REMOVE, h1, g1, '0);
        send_request(CMD_READ_PREV, h1, g1, '0);
        send_request(CMD_REMOVE, h2, g2, '0);
        send_request(CMD_INSERT, 10'd0, 8'd0, {$urandom, $urandom});
        send_request(CMD_INSERT, 10'd0, 8'd0, {$urandom, $urandom});
        h1 = IDX_FIELD_W'(board.last_slot);
        g1 = board.last_gen;
        send_request(CMD_WRITE_CUR, h2, g2, '1);
        drain_results();
        // capacity below the high-water mark: growth stops, reuse still works
        set_capacity(0);
        send_request(CMD_INSERT, 10'd0, 8'd0, '1);
        send_request(CMD_REMOVE, h1, g1, '0);
        send_request(CMD_INSERT, 10'd0, 8'd0, '1);

        caps = '{2047, 1, 5, 0, 1024, 12, $urandom_range(0, 2047)};
        foreach (caps[p]) begin
            drain_results();
            set_capacity(caps[p]);
            repeat (30) random_request();
        end

        // one slot cycled through insert and remove
        drain_results();
        set_capacity(2);
        for (int n = 0; n < 80; n++) begin
            send_request(CMD_INSERT, IDX_FIELD_W'($urandom_range(0, 1023)),
                         GEN_W'($urandom_range(0, 255)), {$urandom, $urandom});
            if (board.last_status == STAT_OK) begin
                wi = IDX_FIELD_W'(board.last_slot);
                wg = board.last_gen;
                if ($urandom_range(0, 3) == 0)
                    send_request(cmd_t'($urandom_range(CMD_CONTAINS, CMD_READ_PREV)), wi, wg,
                                 {$urandom, $urandom});
                send_request(CMD_REMOVE, wi, wg, {$urandom, $urandom});
            end else begin
                for (int k = 1; k < board.high_water; k++) begin
                    if (board.live[k]) begin
                        send_request(CMD_REMOVE, IDX_FIELD_W'(k), board.slot_gen[k], '0);
                        break;
                    end
                end
            end
        end

        drain_results();
        repeat (20) @(negedge aclk);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
